@@ rtl/rhc_pkg.sv @@
// rhc_pkg: shared widths, sector codes and the record passed along the
// divider cells of the rgb to hsv converter
// no dependencies
package rhc_pkg;

    localparam int unsigned CHAN_W    = 16;  // input channels, value, range
    localparam int unsigned HUE_Q_W   = 9;   // hue quotient, 0 to 359
    localparam int unsigned SAT_Q_W   = 16;  // saturation quotient
    localparam int unsigned NUM_W     = 19;  // hue numerator, below 6 * range
    localparam int unsigned HREM_W    = 25;  // 60 * numerator, below 360 * range
    localparam int unsigned SREM_W    = 32;  // 65535 * range
    localparam int unsigned NUM_CELLS = SAT_Q_W;

    // sector of the largest channel
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_sel;

    // payload handed from one divider cell to the next
    typedef struct packed {
        logic                grey;
        logic [CHAN_W-1:0]   range;
        logic [CHAN_W-1:0]   brightness;
        logic [HREM_W-1:0]   hue_rem;
        logic [HUE_Q_W-1:0]  hue_q;
        logic [SREM_W-1:0]   sat_rem;
        logic [SAT_Q_W-1:0]  sat_q;
    } t_cell_data;

endpackage

@@ rtl/rhc_front.sv @@
// rhc_front: three-stage front end, max/min search, hue numerator and the
// two dividends for the divider cell chain
// depends on rhc_pkg
module rhc_front import rhc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_green,
    input  logic [CHAN_W-1:0] i_blue,
    output logic              o_valid,
    output t_cell_data        o_data
);

    // stage 1 registers
    logic              r_s1_valid;
    logic [CHAN_W-1:0] r_s1_red, r_s1_green, r_s1_blue, r_s1_hi, r_s1_range;
    t_sel              r_s1_sel;
    logic [CHAN_W-1:0] n_s1_hi, n_s1_lo;
    t_sel              n_s1_sel;

    // stage 2 registers
    logic              r_s2_valid;
    logic [NUM_W-1:0]  r_s2_num;
    logic [CHAN_W-1:0] r_s2_range, r_s2_hi;
    logic              r_s2_grey;
    logic [NUM_W-1:0]  n_s2_num;

    // stage 3 registers
    logic              r_s3_valid;
    t_cell_data        r_s3_data;
    t_cell_data        n_s3_data;

    // max and min with red over green over blue on ties
    always_comb begin
        n_s1_hi  = i_red;
        n_s1_lo  = i_green;
        n_s1_sel = SEL_RED;
        if (n_s1_hi < i_green) begin
            n_s1_hi  = i_green;
            n_s1_lo  = i_red;
            n_s1_sel = SEL_GREEN;
        end
        if (n_s1_hi < i_blue) begin
            n_s1_hi  = i_blue;
            n_s1_sel = SEL_BLUE;
        end
        if (n_s1_lo > i_blue) begin
            n_s1_lo = i_blue;
        end
    end

    // numerator in units of range, always non-negative
    always_comb begin
        logic [NUM_W:0] w_rng;
        logic [NUM_W:0] w_diff;
        logic [NUM_W:0] w_sum;
        w_rng    = (NUM_W+1)'(r_s1_range);
        w_diff   = '0;
        w_sum    = '0;
        n_s2_num = '0;
        case (r_s1_sel)
            SEL_RED: begin
                w_diff   = (NUM_W+1)'(r_s1_green) - (NUM_W+1)'(r_s1_blue);
                w_sum    = w_diff + (w_rng << 2) + (w_rng << 1);
                n_s2_num = w_diff[NUM_W] ? w_sum[NUM_W-1:0] : w_diff[NUM_W-1:0];
            end
            SEL_GREEN: begin
                w_sum    = (w_rng << 1) + (NUM_W+1)'(r_s1_blue) - (NUM_W+1)'(r_s1_red);
                n_s2_num = w_sum[NUM_W-1:0];
            end
            SEL_BLUE: begin
                w_sum    = (w_rng << 2) + (NUM_W+1)'(r_s1_red) - (NUM_W+1)'(r_s1_green);
                n_s2_num = w_sum[NUM_W-1:0];
            end
            default: begin
                n_s2_num = '0;
            end
        endcase
    end

    // times 60 and times 65535 as shift and subtract
    always_comb begin
        n_s3_data            = '0;
        n_s3_data.grey       = r_s2_grey;
        n_s3_data.range      = r_s2_range;
        n_s3_data.brightness = r_s2_hi;
        n_s3_data.hue_rem    = (HREM_W'(r_s2_num) << 6) - (HREM_W'(r_s2_num) << 2);
        n_s3_data.sat_rem    = (SREM_W'(r_s2_range) << CHAN_W) - SREM_W'(r_s2_range);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_red   <= i_red;
        r_s1_green <= i_green;
        r_s1_blue  <= i_blue;
        r_s1_hi    <= n_s1_hi;
        r_s1_sel   <= n_s1_sel;
        r_s1_range <= n_s1_hi - n_s1_lo;
        r_s2_num   <= n_s2_num;
        r_s2_range <= r_s1_range;
        r_s2_hi    <= r_s1_hi;
        r_s2_grey  <= (r_s1_range == '0);
        r_s3_data  <= n_s3_data;
    end

    assign o_valid = r_s3_valid;
    assign o_data  = r_s3_data;

endmodule

@@ rtl/rhc_div_cell.sv @@
// rhc_div_cell: one restoring division step for saturation and, in the low
// cells, for hue; registered, hands its record to the next cell
// depends on rhc_pkg
module rhc_div_cell import rhc_pkg::*; #(
    parameter int unsigned BIT = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_valid,
    output t_cell_data o_data
);

    logic               r_valid;
    t_cell_data         r_data;
    t_cell_data         n_data;
    logic [HREM_W-1:0]  w_hue_rem;
    logic [HUE_Q_W-1:0] w_hue_q;

    // hue quotient has fewer bits, the upper cells just pass it on
    generate
        if (BIT < HUE_Q_W) begin : g_hue_step
            always_comb begin
                logic [HREM_W-1:0] w_sh;
                logic              w_bit;
                w_sh      = HREM_W'(i_data.range) << BIT;
                w_bit     = (i_data.hue_rem >= w_sh);
                w_hue_rem = w_bit ? (i_data.hue_rem - w_sh) : i_data.hue_rem;
                w_hue_q   = {i_data.hue_q[HUE_Q_W-2:0], w_bit};
            end
        end else begin : g_hue_pass
            assign w_hue_rem = i_data.hue_rem;
            assign w_hue_q   = i_data.hue_q;
        end
    endgenerate

    always_comb begin
        logic [SREM_W-1:0] w_sh;
        logic              w_bit;
        w_sh           = SREM_W'(i_data.brightness) << BIT;
        w_bit          = (i_data.sat_rem >= w_sh);
        n_data         = i_data;
        n_data.sat_rem = w_bit ? (i_data.sat_rem - w_sh) : i_data.sat_rem;
        n_data.sat_q   = {i_data.sat_q[SAT_Q_W-2:0], w_bit};
        n_data.hue_rem = w_hue_rem;
        n_data.hue_q   = w_hue_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/rgb_to_hsv_converter.sv @@
// rgb_to_hsv_converter: top level, front end, chain of divider cells and
// the output register
// depends on rhc_pkg, rhc_front, rhc_div_cell
//
// One pixel goes in per transaction: drive i_red, i_green, i_blue with start
// high; the pixel is taken at that clock edge. busy is always low, so a new
// pixel may be started in every cycle and the block sustains one pixel per
// clock.
// Each result shows on o_hue, o_saturation and o_brightness for exactly one
// cycle with o_valid high, after it has passed through three front-end
// stages (max/min, hue numerator, dividends), sixteen divider cells that each
// resolve one saturation quotient bit, the low cells also one hue bit, and the
// output register, the first stage loading at the edge that takes the pixel.
// Results leave in the order pixels came in. The receiver cannot stall the
// block and must take each result in the cycle it is shown.
// A grey pixel gives hue 0 and saturation 0.
// Synchronous reset clears every valid flag in the pipeline; pixels in
// flight are dropped and no result appears until a new pixel is started.
module rgb_to_hsv_converter import rhc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CHAN_W-1:0]  i_red,
    input  logic [CHAN_W-1:0]  i_green,
    input  logic [CHAN_W-1:0]  i_blue,
    output logic               o_valid,
    output logic [HUE_Q_W-1:0] o_hue,
    output logic [SAT_Q_W-1:0] o_saturation,
    output logic [CHAN_W-1:0]  o_brightness
);

    logic               w_accept;
    logic               w_valid [0:NUM_CELLS];
    t_cell_data         w_data  [0:NUM_CELLS];

    logic               r_valid;
    logic [HUE_Q_W-1:0] r_hue;
    logic [SAT_Q_W-1:0] r_sat;
    logic [CHAN_W-1:0]  r_bright;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_valid[0]),
        .o_data  (w_data[0])
    );

    // most significant quotient bit first
    genvar k;
    generate
        for (k = 0; k < NUM_CELLS; k++) begin : g_cell
            rhc_div_cell #(
                .BIT (NUM_CELLS - 1 - k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .i_data  (w_data[k]),
                .o_valid (w_valid[k+1]),
                .o_data  (w_data[k+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_valid[NUM_CELLS];
        end
    end

    // divide by zero on grey pixels, force both to zero
    always_ff @(posedge i_clk) begin
        r_hue    <= w_data[NUM_CELLS].grey ? '0 : w_data[NUM_CELLS].hue_q;
        r_sat    <= w_data[NUM_CELLS].grey ? '0 : w_data[NUM_CELLS].sat_q;
        r_bright <= w_data[NUM_CELLS].brightness;
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule
